[sv/tlph_pkg.sv]
// package for the tagged linear probe hash table
// holds state encoding, operation codes and fixed field widths; no dependencies
package tlph_pkg;

    // fixed field widths
    localparam int FUNC_W     = 3;
    localparam int WORD_W     = 64;
    localparam int START_W    = 10;
    localparam int SLOT_OUT_W = 10;
    localparam int ENTRY_W    = 11;
    localparam int LIMIT_W    = 10;
    localparam int TAG_W      = 8;
    localparam int PRINT_W    = 7;
    localparam int PRINT_LSB  = 56;
    localparam int S_DATA_W   = 144;
    localparam int M_DATA_W   = 96;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd512;
    localparam logic [PRINT_W-1:0] PRINT_FLIP  = 7'h7f;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP      = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP_INS  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_INSERT      = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_DISABLE     = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_NEXT_OCC    = 3'd4;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HOME,
        ST_PROBE,
        ST_DONE
    } state_t;

endpackage

[sv/tlph_tag_mem.sv]
// tag memory: one byte per slot, fill bit and fingerprint
// swept to zero after reset; uses tlph_pkg
module tlph_tag_mem #(
    parameter int SLOTS = 1024,
    parameter int IDX_W = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [IDX_W-1:0]           rd_addr,
    output logic [tlph_pkg::TAG_W-1:0] rd_data,
    input  logic                       wr_en,
    input  logic [IDX_W-1:0]           wr_addr,
    input  logic [tlph_pkg::TAG_W-1:0] wr_data,
    output logic                       clr_busy
);
    import tlph_pkg::*;

    localparam logic [IDX_W-1:0] SLOT_LAST = IDX_W'(SLOTS - 1);

    logic [TAG_W-1:0] mem [SLOTS];
    logic [IDX_W-1:0] clr_addr_reg;
    logic [IDX_W-1:0] clr_addr_next;
    logic             clr_busy_reg;
    logic             clr_busy_next;
    logic             we;
    logic [IDX_W-1:0] wa;
    logic [TAG_W-1:0] wd;

    // clearing sweep, one slot a cycle
    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == SLOT_LAST)
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    // write port shared between the sweep and the probe logic
    assign we = clr_busy_reg | wr_en;
    assign wa = clr_busy_reg ? clr_addr_reg : wr_addr;
    assign wd = clr_busy_reg ? '0 : wr_data;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_data <= mem[rd_addr];
    end

    assign clr_busy = clr_busy_reg;

endmodule

[sv/tlph_key_mem.sv]
// key memory: one key per slot, contents undefined until written
// uses tlph_pkg only for the import convention
module tlph_key_mem #(
    parameter int SLOTS    = 1024,
    parameter int IDX_W    = 10,
    parameter int KEY_BITS = 64
) (
    input  logic                clk,
    input  logic [IDX_W-1:0]    rd_addr,
    output logic [KEY_BITS-1:0] rd_data,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_addr,
    input  logic [KEY_BITS-1:0] wr_data
);
    import tlph_pkg::*;

    logic [KEY_BITS-1:0] mem [SLOTS];

    // single write port, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[sv/tagged_linear_probe_hash_table.sv]
// top level of the tagged linear probe hash table: probe sequencer and result register
// depends on tlph_pkg, tlph_tag_mem and tlph_key_mem
//
// channel   | direction | contents
// s_axis    | in        | tdata: key, hash, start_index; tuser: func
// m_axis    | out       | tdata: found, is_new, slot_index, table_full, scan_end,
//           |           |        stored_key, entry_count
// fill_limit| in        | cfg_we / cfg_wdata, written on any edge with cfg_we high
//
// an item runs home reduction when SLOTS is not a power of two, then probes one slot
// per cycle (one tag/key memory read each), then moves its result to the output register
// after reset the tag memory is swept to zero; s_tready stays low
// the next item is taken while a result waits in the output register
module tagged_linear_probe_hash_table #(
    parameter int SLOTS    = 1024,
    parameter int KEY_BITS = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [63:0] key, [127:64] hash, [137:128] start_index, rest zero
    input  logic [tlph_pkg::S_DATA_W-1:0]      s_tdata,
    // [2:0] func
    input  logic [tlph_pkg::FUNC_W-1:0]        s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [0] found, [1] is_new, [11:2] slot_index, [12] table_full, [13] scan_end,
    // [77:14] stored_key, [88:78] entry_count, rest zero
    output logic [tlph_pkg::M_DATA_W-1:0]      m_tdata,
    input  logic                               cfg_we,
    input  logic [tlph_pkg::LIMIT_W-1:0]       cfg_wdata
);
    import tlph_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CMP_W = ((IDX_W > START_W) ? IDX_W : START_W) + 1;
    localparam bit IS_POW2 = ((SLOTS & (SLOTS - 1)) == 0);
    localparam logic [IDX_W-1:0] SLOT_LAST = IDX_W'(SLOTS - 1);
    localparam logic [IDX_W:0]   SLOTS_W1  = (IDX_W + 1)'(SLOTS);
    localparam logic [CMP_W-1:0] SLOTS_CMP = CMP_W'(SLOTS);

    state_t state_reg, state_next;

    logic [FUNC_W-1:0]   func_reg, func_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [PRINT_W-1:0]  print_reg, print_next;
    logic [WORD_W-1:0]   hash_reg, hash_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [IDX_W-1:0]    cnt_reg, cnt_next;
    logic [2:0]          step_reg, step_next;
    logic [ENTRY_W-1:0]  entries_reg, entries_next;
    logic [LIMIT_W-1:0]  limit_reg, limit_next;

    logic                res_found_reg, res_found_next;
    logic                res_new_reg, res_new_next;
    logic [IDX_W-1:0]    res_slot_reg, res_slot_next;
    logic                res_full_reg, res_full_next;
    logic                res_scan_reg, res_scan_next;
    logic [KEY_BITS-1:0] res_key_reg, res_key_next;

    logic                m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;

    logic [FUNC_W-1:0]   in_func;
    logic [KEY_BITS-1:0] in_key;
    logic [WORD_W-1:0]   in_hash;
    logic [CMP_W-1:0]    in_start;
    logic                accept;
    logic                clr_busy;

    logic [TAG_W-1:0]    tag_rd;
    logic [KEY_BITS-1:0] key_rd;
    logic [IDX_W-1:0]    rd_addr;
    logic                tag_we;
    logic [TAG_W-1:0]    tag_wd;
    logic                key_we;

    logic [IDX_W-1:0]    rem_step;
    logic [IDX_W-1:0]    idx_adv;
    logic                is_full;
    logic                filled, hit, last_idx, exhaust;
    logic                fin, place, op_probe;
    logic                p_found, p_full, p_scan;

    // input unpacking
    assign in_key   = s_tdata[KEY_BITS-1:0];
    assign in_hash  = s_tdata[2*WORD_W-1:WORD_W];
    assign in_start = CMP_W'(s_tdata[2*WORD_W+START_W-1:2*WORD_W]);
    assign in_func  = s_tuser;
    assign s_tready = (state_reg == ST_IDLE) && !clr_busy;
    assign accept   = s_tvalid && s_tready;

    assign is_full = entries_reg >= ENTRY_W'(limit_reg);
    assign idx_adv = (idx_reg == SLOT_LAST) ? '0 : idx_reg + 1'b1;

    // home slot reduction, eight hash bits a cycle from the top
    always_comb
    begin
        logic [IDX_W:0] t;
        t = '0;
        rem_step = idx_reg;
        for (int i = 0; i < 8; i++)
        begin
            t = {rem_step, hash_reg[WORD_W-1-i]};
            if (t >= SLOTS_W1)
            begin
                t = t - SLOTS_W1;
            end
            rem_step = t[IDX_W-1:0];
        end
    end

    // slot evaluation on the tag and key read back
    always_comb
    begin
        filled   = tag_rd[TAG_W-1];
        hit      = filled && (tag_rd[PRINT_W-1:0] == print_reg) && (key_rd == key_reg);
        last_idx = idx_reg == SLOT_LAST;
        exhaust  = cnt_reg == SLOT_LAST;
        op_probe = (func_reg == FUNC_LOOKUP) || (func_reg == FUNC_LOOKUP_INS)
                   || (func_reg == FUNC_DISABLE);
        fin      = 1'b1;
        place    = 1'b0;
        p_found  = 1'b0;
        p_full   = 1'b0;
        p_scan   = 1'b0;
        if (func_reg == FUNC_NEXT_OCC)
        begin
            fin     = filled || last_idx;
            p_found = filled;
            p_scan  = !filled;
        end
        else if (func_reg == FUNC_INSERT)
        begin
            fin    = !filled || exhaust;
            place  = !filled;
            p_full = filled;
        end
        else if (op_probe)
        begin
            fin     = !filled || hit || exhaust;
            p_found = hit;
            if (func_reg == FUNC_LOOKUP_INS && !hit)
            begin
                place  = !filled && !is_full;
                p_full = filled || is_full;
            end
        end
    end

    // memory write and read control
    always_comb
    begin
        tag_we = 1'b0;
        key_we = 1'b0;
        tag_wd = {1'b1, print_reg};
        if (state_reg == ST_PROBE && fin)
        begin
            if (place)
            begin
                tag_we = 1'b1;
                key_we = 1'b1;
            end
            else if (func_reg == FUNC_DISABLE && hit)
            begin
                tag_we = 1'b1;
                tag_wd = {tag_rd[TAG_W-1], tag_rd[PRINT_W-1:0] ^ PRINT_FLIP};
            end
        end
        rd_addr = idx_reg;
        if (accept)
        begin
            rd_addr = (in_func == FUNC_NEXT_OCC) ? IDX_W'(in_start) : in_hash[IDX_W-1:0];
        end
        else if (state_reg == ST_HOME)
        begin
            rd_addr = rem_step;
        end
        else if (state_reg == ST_PROBE && !fin)
        begin
            rd_addr = idx_adv;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (!clr_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (in_func == FUNC_NEXT_OCC)
                    begin
                        state_next = (in_start < SLOTS_CMP) ? ST_PROBE : ST_DONE;
                    end
                    else if (in_func == FUNC_INSERT && is_full)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (in_func == FUNC_LOOKUP || in_func == FUNC_LOOKUP_INS
                             || in_func == FUNC_INSERT || in_func == FUNC_DISABLE)
                    begin
                        state_next = IS_POW2 ? ST_PROBE : ST_HOME;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_HOME:
            begin
                if (step_reg == 3'd7)
                begin
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if (fin)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and result registers
    always_comb
    begin
        func_next      = func_reg;
        key_next       = key_reg;
        print_next     = print_reg;
        hash_next      = hash_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        step_next      = step_reg;
        entries_next   = entries_reg;
        limit_next     = cfg_we ? cfg_wdata : limit_reg;
        res_found_next = res_found_reg;
        res_new_next   = res_new_reg;
        res_slot_next  = res_slot_reg;
        res_full_next  = res_full_reg;
        res_scan_next  = res_scan_reg;
        res_key_next   = res_key_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;

        if (accept)
        begin
            func_next      = in_func;
            key_next       = in_key;
            print_next     = in_hash[PRINT_LSB+PRINT_W-1:PRINT_LSB];
            hash_next      = in_hash;
            idx_next       = IS_POW2 ? rd_addr : '0;
            if (in_func == FUNC_NEXT_OCC)
            begin
                idx_next = rd_addr;
            end
            cnt_next       = '0;
            step_next      = '0;
            res_found_next = 1'b0;
            res_new_next   = 1'b0;
            res_slot_next  = '0;
            res_full_next  = (in_func == FUNC_INSERT) && is_full;
            res_scan_next  = (in_func == FUNC_NEXT_OCC);
            res_key_next   = '0;
        end

        if (state_reg == ST_HOME)
        begin
            hash_next = hash_reg << 8;
            idx_next  = rem_step;
            step_next = step_reg + 1'b1;
        end

        if (state_reg == ST_PROBE)
        begin
            if (fin)
            begin
                res_found_next = p_found;
                res_new_next   = place;
                res_full_next  = p_full;
                res_scan_next  = p_scan;
                res_slot_next  = (p_found || place) ? idx_reg : '0;
                res_key_next   = place ? key_reg : (p_found ? key_rd : '0);
                if (place)
                begin
                    entries_next = entries_reg + 1'b1;
                end
            end
            else
            begin
                idx_next = idx_adv;
                cnt_next = cnt_reg + 1'b1;
            end
        end

        if (state_reg == ST_DONE && (!m_valid_reg || m_tready))
        begin
            m_valid_next = 1'b1;
            m_data_next  = M_DATA_W'({entries_reg, WORD_W'(res_key_reg), res_scan_reg,
                                      res_full_reg, SLOT_OUT_W'(res_slot_reg),
                                      res_new_reg, res_found_reg});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            entries_reg <= '0;
            limit_reg   <= LIMIT_RESET;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            entries_reg <= entries_next;
            limit_reg   <= limit_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        key_reg       <= key_next;
        print_reg     <= print_next;
        hash_reg      <= hash_next;
        idx_reg       <= idx_next;
        cnt_reg       <= cnt_next;
        step_reg      <= step_next;
        res_found_reg <= res_found_next;
        res_new_reg   <= res_new_next;
        res_slot_reg  <= res_slot_next;
        res_full_reg  <= res_full_next;
        res_scan_reg  <= res_scan_next;
        res_key_reg   <= res_key_next;
        m_data_reg    <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // slot memories
    tlph_tag_mem #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_tag_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_addr  (rd_addr),
        .rd_data  (tag_rd),
        .wr_en    (tag_we),
        .wr_addr  (idx_reg),
        .wr_data  (tag_wd),
        .clr_busy (clr_busy)
    );

    tlph_key_mem #(
        .SLOTS    (SLOTS),
        .IDX_W    (IDX_W),
        .KEY_BITS (KEY_BITS)
    ) u_key_mem (
        .clk     (clk),
        .rd_addr (rd_addr),
        .rd_data (key_rd),
        .wr_en   (key_we),
        .wr_addr (idx_reg),
        .wr_data (key_reg)
    );

    // entry count only ever steps up by one
    a_entries_step: assert property (@(posedge clk) disable iff (!rst_n)
        (entries_reg != $past(entries_reg)) |-> (entries_reg == $past(entries_reg) + 1'b1))
        else $error("entry count changed by other than one");

    // the probe logic writes the slot memories only while a probe finishes
    a_write_in_probe: assert property (@(posedge clk) disable iff (!rst_n)
        (tag_we || key_we) |-> (state_reg == ST_PROBE))
        else $error("slot write outside probe");

    // a new result comes only out of the done state
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result loaded outside done state");

endmodule
